/* rtl/ssef_pkg.sv */
package ssef_pkg;

  // One RGB pixel, red in the top byte.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // One window column: row above, current row, row below.
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  // One line-store entry: both stored rows at one column.
  typedef struct packed {
    pixel_t up;
    pixel_t md;
  } line_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 2'd3;

  localparam logic MODE_SHARPEN = 1'b0;
  localparam logic MODE_EDGE    = 1'b1;

  // Q16 luma weights, summing to 65536.
  localparam logic [23:0] GRAY_R = 24'd19595;
  localparam logic [23:0] GRAY_G = 24'd38470;
  localparam logic [23:0] GRAY_B = 24'd7471;

  localparam logic [11:0] RESET_WIDTH  = 12'd1024;
  localparam logic [11:0] RESET_HEIGHT = 12'd768;

endpackage

/* rtl/ssef_line.sv */
module ssef_line #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(MAX_WIDTH)-1:0] waddr,
  input  ssef_pkg::line_t              wdata,
  input  logic                         re,
  input  logic [$clog2(MAX_WIDTH)-1:0] raddr,
  output ssef_pkg::line_t              rdata
);
  import ssef_pkg::*;

  line_t mem_r [MAX_WIDTH];
  line_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/ssef_cell.sv */
module ssef_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift,
  input  ssef_pkg::column_t d,
  output ssef_pkg::column_t q
);
  import ssef_pkg::*;

  column_t col_r;

  // Take the neighbor's column on every shift.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift) begin
      col_r <= d;
    end
  end

  assign q = col_r;

endmodule

/* rtl/ssef_kern.sv */
module ssef_kern (
  input  logic       mode,
  input  logic [7:0] thr,
  input  logic [7:0] t,
  input  logic [7:0] m,
  input  logic [7:0] b,
  input  logic [7:0] l,
  input  logic [7:0] r,
  output logic [7:0] y
);
  import ssef_pkg::*;

  logic [11:0] pos;
  logic [11:0] neg;
  logic [11:0] diff;
  logic [7:0]  clamped;

  always_comb begin
    // 4*m, plus m again in sharpen mode
    pos  = {2'b00, m, 2'b00} + ((mode == MODE_EDGE) ? 12'd0 : {4'd0, m});
    neg  = {4'd0, t} + {4'd0, b} + {4'd0, l} + {4'd0, r};
    diff = pos - neg;
    if (neg >= pos) begin
      clamped = 8'd0;
    end else if (diff > 12'd255) begin
      clamped = 8'd255;
    end else begin
      clamped = diff[7:0];
    end
    if (mode == MODE_EDGE) begin
      y = (clamped > thr) ? 8'd255 : 8'd0;
    end else begin
      y = clamped;
    end
  end

endmodule

/* rtl/stencil_sharpen_edge_filter.sv */
// Streaming 3x3 cross-kernel filter over RGB raster pixels, one word per clock
// sustained while the output is not stalled; a stalled, full output register raises in_stall.
// Sharpen mode gives 5*centre minus the four neighbors per channel; edge mode
// turns each pixel gray on arrival (Q16 luma, truncated), applies 4*centre
// minus the neighbors and thresholds to 0 or 255. Borders clamp to the nearest
// pixel. Results lag input by one row plus one pixel; after the frame, send
// image_width+1 drain words to flush the rest (drain words during the frame
// are dropped, pixels during the flush act as drains). frame_end marks the
// last result of the frame. Two line stores live in one dual-port memory of
// MAX_WIDTH entries; the window is a chain of two column cells that shift on
// every pixel. A word passes the execute stage, then the output register. The
// memory needs no clearing pass: an entry read before it is written never
// reaches a result in a regular frame. Write configuration only while idle.
module stencil_sharpen_edge_filter #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_red_in,
  input  logic [7:0]                          in_green_in,
  input  logic [7:0]                          in_blue_in,
  input  logic                                in_drain,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_red_out,
  output logic [7:0]                          out_green_out,
  output logic [7:0]                          out_blue_out,
  output logic                                out_frame_end,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ssef_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssef_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ssef_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
  localparam int RW = ($clog2(MAX_HEIGHT + 3) > 12) ? $clog2(MAX_HEIGHT + 3) : 12;

  // Configuration registers
  logic        mode_r;
  logic [7:0]  thr_r;
  logic [11:0] width_r;
  logic [11:0] height_r;

  // Raster position of the next input word
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  // Execute stage: one word between accept and the output register
  logic          s1_valid_r, s1_valid_nxt;
  logic [AW-1:0] s1_addr_r;
  pixel_t        s1_pix_r;
  logic          s1_has_pix_r;
  logic          s1_top_md_r;
  logic          s1_lsel_r;
  logic          s1_edge_r;
  logic          s1_fin_r;
  logic          s1_em2_r;
  logic          s1_fwd_r;
  line_t         s1_fwd_r_data;

  // Output register
  logic   out_valid_r;
  pixel_t out_pix_r;
  logic   out_end_r;

  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [CW-1:0] c_a, c_inc;
  logic [RW-1:0] r_a;
  logic          accept, advance, consume;
  logic          ign, fin, edge_a, em2, has_pix, top_md, lsel;
  logic [AW-1:0] addr_a;
  logic [23:0]   gray_sum;
  pixel_t        pix_a;

  line_t   rd_line, wr_line, stored;
  pixel_t  pix_new, top_new;
  column_t col_in, c1_q, c2_q;
  pixel_t  k_left, k_right, k_out;
  logic    emit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_SHARPEN;
      thr_r    <= 8'd0;
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FILTER_MODE:     mode_r   <= cfg_data[0];
        CFG_THRESHOLD_LEVEL: thr_r    <= cfg_data[7:0];
        CFG_IMAGE_WIDTH:     width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT:    height_r <= cfg_data;
        default:             mode_r   <= mode_r;
      endcase
    end
  end

  // Effective frame size: zero reads as one, oversize saturates.
  always_comb begin
    if (width_r == 12'd0) begin
      w_eff = CW'(1);
    end else if (CW'(width_r) > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_r);
    end
    if (height_r == 12'd0) begin
      h_eff = RW'(1);
    end else if (RW'(height_r) > RW'(MAX_HEIGHT)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(height_r);
    end
  end

  // Handshake: the execute stage drains whenever the output register frees.
  assign advance  = !out_valid_r || !out_stall;
  assign consume  = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  // Accept side: normalize position, decode what this word does.
  always_comb begin
    c_a = col_r;
    r_a = row_r;
    if (c_a >= w_eff) begin
      c_a = '0;
      r_a = row_r + RW'(1);
    end
    if (r_a > h_eff + RW'(1)) begin
      c_a = '0;
      r_a = '0;
    end
    has_pix = r_a < h_eff;
    ign     = has_pix && in_drain;
    // the frame closes only on the first column of the row past the flush row
    fin     = (c_a == '0) && (r_a == h_eff + RW'(1));
    edge_a  = (c_a == '0) && (r_a >= RW'(2));
    em2     = (c_a != '0) && (r_a != '0);
    top_md  = r_a == RW'(1);
    lsel    = edge_a ? (w_eff == CW'(1)) : (c_a == CW'(1));
    addr_a  = c_a[AW-1:0];
    c_inc   = c_a + CW'(1);

    if (fin) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (ign) begin
      col_nxt = c_a;
      row_nxt = r_a;
    end else if (c_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = r_a + RW'(1);
    end else begin
      col_nxt = c_inc;
      row_nxt = r_a;
    end

    gray_sum = GRAY_R * {16'd0, in_red_in} + GRAY_G * {16'd0, in_green_in}
             + GRAY_B * {16'd0, in_blue_in};
    if (mode_r == MODE_EDGE) begin
      pix_a = '{red: gray_sum[23:16], green: gray_sum[23:16], blue: gray_sum[23:16]};
    end else begin
      pix_a = '{red: in_red_in, green: in_green_in, blue: in_blue_in};
    end
  end

  assign s1_valid_nxt = accept ? !ign : (consume ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Stage payload; forward the store write of the word leaving this cycle
  // when it hits the column just read.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r     <= addr_a;
      s1_pix_r      <= pix_a;
      s1_has_pix_r  <= has_pix;
      s1_top_md_r   <= top_md;
      s1_lsel_r     <= lsel;
      s1_edge_r     <= edge_a;
      s1_fin_r      <= fin;
      s1_em2_r      <= em2;
      s1_fwd_r      <= consume && !s1_fin_r && (s1_addr_r == addr_a);
      s1_fwd_r_data <= wr_line;
    end
  end

  ssef_line #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (consume && !s1_fin_r),
    .waddr (s1_addr_r),
    .wdata (wr_line),
    .re    (accept),
    .raddr (addr_a),
    .rdata (rd_line)
  );

  // Execute side: build the new column, write back both rows.
  always_comb begin
    stored  = s1_fwd_r ? s1_fwd_r_data : rd_line;
    pix_new = s1_has_pix_r ? s1_pix_r : stored.md;
    top_new = s1_top_md_r ? stored.md : stored.up;
    wr_line = '{up: stored.md, md: pix_new};
    col_in  = '{top: top_new, mid: stored.md, bot: pix_new};
    k_left  = s1_lsel_r ? c2_q.mid : c1_q.mid;
    k_right = s1_edge_r ? c2_q.mid : stored.md;
    emit    = s1_edge_r || s1_em2_r;
  end

  // Newest column, then the one before it.
  ssef_cell u_cell_new (
    .clk   (clk),
    .rst_n (rst_n),
    .shift (consume && !s1_fin_r),
    .d     (col_in),
    .q     (c2_q)
  );

  ssef_cell u_cell_old (
    .clk   (clk),
    .rst_n (rst_n),
    .shift (consume && !s1_fin_r),
    .d     (c2_q),
    .q     (c1_q)
  );

  ssef_kern u_kern_r (
    .mode (mode_r), .thr (thr_r),
    .t (c2_q.top.red), .m (c2_q.mid.red), .b (c2_q.bot.red),
    .l (k_left.red), .r (k_right.red), .y (k_out.red)
  );

  ssef_kern u_kern_g (
    .mode (mode_r), .thr (thr_r),
    .t (c2_q.top.green), .m (c2_q.mid.green), .b (c2_q.bot.green),
    .l (k_left.green), .r (k_right.green), .y (k_out.green)
  );

  ssef_kern u_kern_b (
    .mode (mode_r), .thr (thr_r),
    .t (c2_q.top.blue), .m (c2_q.mid.blue), .b (c2_q.bot.blue),
    .l (k_left.blue), .r (k_right.blue), .y (k_out.blue)
  );

  // Output register: load a result, hold it while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= consume && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && consume && emit) begin
      out_pix_r <= k_out;
      out_end_r <= s1_edge_r && s1_fin_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_pix_r.red;
  assign out_green_out = out_pix_r.green;
  assign out_blue_out  = out_pix_r.blue;
  assign out_frame_end = out_end_r;

endmodule

/* dv/stencil_sharpen_edge_filter_tb.sv */
`timescale 1ns / 100ps

module stencil_sharpen_edge_filter_tb;
  import ssef_pkg::*;

  localparam int MAXW        = 2048;
  localparam int MAXH        = 2048;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 8;      // margin past the execute stage and output register

  // Pixel patterns for the stimulus.
  localparam int PAT_RANDOM  = 0;
  localparam int PAT_EXTREME = 1;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_red_in = '0;
  logic [7:0]            in_green_in = '0;
  logic [7:0]            in_blue_in = '0;
  logic                  in_drain = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_red_out;
  logic [7:0]            out_green_out;
  logic [7:0]            out_blue_out;
  logic                  out_frame_end;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  stencil_sharpen_edge_filter i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red_in(in_red_in), .in_green_in(in_green_in),
    .in_blue_in(in_blue_in), .in_drain(in_drain),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red_out(out_red_out), .out_green_out(out_green_out),
    .out_blue_out(out_blue_out), .out_frame_end(out_frame_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Filter state mirror: registers, line stores, 3x3 window, raster position.
  logic        mode_q;
  logic [7:0]  level_q;
  logic [11:0] width_q;
  logic [11:0] height_q;
  pixel_t      upper_st [MAXW];
  pixel_t      middle_st[MAXW];
  pixel_t      win[3][3];          // [column oldest..newest][row top..bottom]
  int unsigned col_pos;
  int unsigned row_pos;

  result_t     pending_q[$];
  int          mismatches = 0;
  int          words_sent = 0;
  int          cycles = 0;
  bit          no_idle = 1'b0;     // when set, both sides run back to back

  function automatic int unsigned clip_dim(logic [11:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [7:0] stencil_chan(int t, int m, int b, int l, int r);
    int s;
    s = (mode_q == MODE_EDGE ? 4 : 5) * m - t - b - l - r;
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    if (mode_q == MODE_EDGE) s = (s > level_q) ? 255 : 0;
    return s[7:0];
  endfunction

  function automatic result_t stencil_px(pixel_t t, pixel_t m, pixel_t b, pixel_t l,
                                         pixel_t r, logic last);
    result_t e;
    e.red       = stencil_chan(t.red, m.red, b.red, l.red, r.red);
    e.green     = stencil_chan(t.green, m.green, b.green, l.green, r.green);
    e.blue      = stencil_chan(t.blue, m.blue, b.blue, l.blue, r.blue);
    e.frame_end = last;
    return e;
  endfunction

  // Advance the mirror by one accepted word; return 1 with the result it causes.
  function automatic bit filter_word(pixel_t p, logic drain, output result_t e);
    int unsigned w, h, c, r, g;
    pixel_t      up, md, pix, top, mid, left;
    bit          got;
    w = clip_dim(width_q, MAXW);
    h = clip_dim(height_q, MAXH);
    got = 0;
    e = '{default: '0};
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos > h + 1) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    // drop drains inside the frame
    if (r < h && drain) return 0;
    if (c == 0 && r >= 2) begin
      // right-edge pixel of row r-2
      mid = win[2][1];
      left = (w == 1) ? mid : win[1][1];
      e = stencil_px(win[2][0], mid, win[2][2], left, mid, (r - 2) == h - 1);
      got = 1;
      if (r == h + 1) begin
        col_pos = 0;
        row_pos = 0;
        return 1;
      end
    end
    up = upper_st[c];
    md = middle_st[c];
    if (r < h) begin
      if (mode_q == MODE_EDGE) begin
        g = (19595 * p.red + 38470 * p.green + 7471 * p.blue) >> 16;
        pix = '{g[7:0], g[7:0], g[7:0]};
      end else begin
        pix = p;
      end
    end else begin
      pix = md;       // below the last row, clamp to it
    end
    top = (r == 1) ? md : up;
    win[0] = win[1];
    win[1] = win[2];
    win[2][0] = top;
    win[2][1] = md;
    win[2][2] = pix;
    upper_st[c] = md;
    middle_st[c] = pix;
    if (c >= 1 && r >= 1) begin
      left = (c == 1) ? win[1][1] : win[0][1];
      e = stencil_px(win[1][0], win[1][1], win[1][2], left, win[2][1], 1'b0);
      got = 1;
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end
    return got;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  // Send one word and predict its result at the accepting edge.
  task automatic send_word(pixel_t p, logic drain);
    int      gap;
    result_t e;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_red_in   <= p.red;
    in_green_in <= p.green;
    in_blue_in  <= p.blue;
    in_drain    <= drain;
    do @(posedge clk); while (in_stall);
    if (filter_word(p, drain, e)) pending_q.push_back(e);
    words_sent++;
  endtask

  // Hold input, let every result come out, then write one register.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FILTER_MODE:     mode_q   = val[0];
      CFG_THRESHOLD_LEVEL: level_q  = val[7:0];
      CFG_IMAGE_WIDTH:     width_q  = val[11:0];
      CFG_IMAGE_HEIGHT:    height_q = val[11:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic setup(int unsigned mode, int unsigned level, int unsigned w,
                       int unsigned h);
    write_reg(CFG_FILTER_MODE, mode);
    write_reg(CFG_THRESHOLD_LEVEL, level);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  // Stream pixels then drains until the frame wraps, or stop after max_words.
  // noise_pct of words take the wrong kind: drains in the frame, pixels in the flush.
  task automatic run_frame(int max_words, int noise_pct, int pattern);
    int unsigned w, h, rr;
    int          n;
    bit          flush, drain;
    pixel_t      p;
    n = 0;
    while (n < max_words) begin
      w = clip_dim(width_q, MAXW);
      h = clip_dim(height_q, MAXH);
      rr = row_pos + (col_pos >= w ? 1 : 0);
      if (rr > h + 1) rr = 0;
      flush = (rr >= h);
      drain = flush;
      if ($urandom_range(0, 99) < noise_pct) drain = !flush;
      if (pattern == PAT_EXTREME)
        p = '{$urandom_range(0, 1) ? 8'hFF : 8'h00, $urandom_range(0, 1) ? 8'hFF : 8'h00,
              $urandom_range(0, 1) ? 8'hFF : 8'h00};
      else
        p = pixel_t'(24'($urandom()));
      send_word(p, drain);
      n++;
      // a dropped drain leaves the position as it was
      if (!(drain && !flush) && row_pos == 0 && col_pos == 0) break;
      if (row_pos > h + 1) break;
    end
  endtask

  task automatic test_sharpen_extremes();
    setup(MODE_SHARPEN, 0, 3, 3);
    run_frame(1 << 30, 0, PAT_EXTREME);
    run_frame(1 << 30, 0, PAT_RANDOM);
  endtask

  task automatic test_edge_levels();
    setup(MODE_EDGE, 0, 4, 3);
    run_frame(1 << 30, 0, PAT_EXTREME);
    write_reg(CFG_THRESHOLD_LEVEL, 255);
    run_frame(1 << 30, 0, PAT_EXTREME);
    write_reg(CFG_THRESHOLD_LEVEL, 40);
    run_frame(1 << 30, 0, PAT_RANDOM);
  endtask

  // Zero sizes act as one; single row and single column frames.
  task automatic test_degenerate_sizes();
    setup(MODE_SHARPEN, 0, 0, 0);
    run_frame(1 << 30, 0, PAT_RANDOM);
    setup(MODE_EDGE, 100, 1, 5);
    run_frame(1 << 30, 0, PAT_RANDOM);
    setup(MODE_SHARPEN, 0, 5, 1);
    run_frame(1 << 30, 0, PAT_RANDOM);
  endtask

  task automatic test_misplaced_words();
    setup(MODE_SHARPEN, 0, 5, 4);
    run_frame(1 << 30, 30, PAT_RANDOM);
  endtask

  // Mode flip, width shrink mid-row and height shrink mid-frame.
  task automatic test_midframe_changes();
    setup(MODE_SHARPEN, 90, 6, 5);
    run_frame(14, 0, PAT_RANDOM);
    write_reg(CFG_FILTER_MODE, MODE_EDGE);
    run_frame(1 << 30, 0, PAT_RANDOM);
    setup(MODE_SHARPEN, 0, 8, 6);
    run_frame(29, 0, PAT_RANDOM);
    write_reg(CFG_IMAGE_WIDTH, 3);
    run_frame(1 << 30, 0, PAT_RANDOM);
    setup(MODE_SHARPEN, 0, 8, 8);
    run_frame(36, 0, PAT_RANDOM);
    write_reg(CFG_IMAGE_HEIGHT, 2);
    run_frame(1 << 30, 0, PAT_RANDOM);
  endtask

  task automatic test_random_frames();
    int start;
    start = words_sent;
    while (words_sent - start < 880) begin
      no_idle = ($urandom_range(0, 4) == 0);
      setup($urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(1, 12),
            $urandom_range(1, 8));
      run_frame(1 << 30, $urandom_range(0, 1) ? 0 : 10,
                $urandom_range(0, 3) == 0 ? PAT_EXTREME : PAT_RANDOM);
    end
    no_idle = 1'b0;
  endtask

  // Receiver: stall at random between words, check each accepted word.
  int hold = 0;
  always @(posedge clk) begin
    result_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: r=%0d g=%0d b=%0d fe=%0b",
                     out_red_out, out_green_out, out_blue_out, out_frame_end);
        end else begin
          e = pending_q.pop_front();
          if (e.red !== out_red_out || e.green !== out_green_out ||
              e.blue !== out_blue_out || e.frame_end !== out_frame_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected r=%0d g=%0d b=%0d fe=%0b, got r=%0d g=%0d b=%0d fe=%0b",
                       e.red, e.green, e.blue, e.frame_end,
                       out_red_out, out_green_out, out_blue_out, out_frame_end);
          end
        end
        hold = draw_gap();
      end else if (hold > 0) begin
        hold--;
      end
      out_stall <= (hold != 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    mode_q   = MODE_SHARPEN;
    level_q  = '0;
    width_q  = RESET_WIDTH;
    height_q = RESET_HEIGHT;
    for (int i = 0; i < MAXW; i++) begin
      upper_st[i]  = '0;
      middle_st[i] = '0;
    end
    win = '{default: '{default: '0}};
    col_pos = 0;
    row_pos = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_sharpen_extremes();
    test_edge_levels();
    test_degenerate_sizes();
    test_misplaced_words();
    test_midframe_changes();
    test_random_frames();

    // drain the result side, then let the pipeline settle
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
